// ===== rtl/tbc_pkg.sv =====
// Package with the shared types and constants of the TEA block cipher.
`timescale 1ns / 1ps

package tbc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;
  localparam int unsigned SHIFT_LEFT = 4;
  localparam int unsigned SHIFT_RIGHT = 5;
  localparam int unsigned SEL_HIGH_LSB = 11;
  localparam int unsigned KEY_IDX_W = 2;

  typedef enum logic {
    OP_DECRYPT = 1'b0,
    OP_ENCRYPT = 1'b1
  } op_e;

  typedef enum logic [KEY_IDX_W-1:0] {
    KEY_WORD_0 = 2'd0,
    KEY_WORD_1 = 2'd1,
    KEY_WORD_2 = 2'd2,
    KEY_WORD_3 = 2'd3
  } key_idx_e;

  typedef logic [3:0][WORD_W-1:0] keys_t;

  typedef struct packed {
    op_e               opcode;
    logic [WORD_W-1:0] block_left;
    logic [WORD_W-1:0] block_right;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_left;
    logic [WORD_W-1:0] out_right;
  } result_t;

  // One block in flight: a is the half updated next, b the half it is mixed from.
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic              phase;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] sum;
  } token_t;

endpackage

// ===== rtl/tbc_cell.sv =====
// One half-round cell of the cipher pipeline.
`timescale 1ns / 1ps

module tbc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tbc_pkg::keys_t  keys_i,
  input  tbc_pkg::token_t tok_i,
  output tbc_pkg::token_t tok_o
);

  logic                       encrypt;
  logic                       use_low;
  logic [tbc_pkg::KEY_IDX_W-1:0] key_idx;
  logic [tbc_pkg::WORD_W-1:0] x;
  logic [tbc_pkg::WORD_W-1:0] mix;
  logic [tbc_pkg::WORD_W-1:0] a_new;
  logic [tbc_pkg::WORD_W-1:0] sum_new;
  logic                       valid_q;
  tbc_pkg::token_t            tok_d;
  tbc_pkg::token_t            tok_q;

  always_comb begin
    encrypt = (tok_i.op == tbc_pkg::OP_ENCRYPT);
    // low key select on the left half: first half-round when encrypting, second when decrypting
    use_low = encrypt ^ tok_i.phase;
    key_idx = use_low ? tok_i.sum[tbc_pkg::KEY_IDX_W-1:0]
                      : tok_i.sum[tbc_pkg::SEL_HIGH_LSB +: tbc_pkg::KEY_IDX_W];
    x       = tok_i.b;
    mix     = ((x << tbc_pkg::SHIFT_LEFT) ^ (x >> tbc_pkg::SHIFT_RIGHT))
              + (x ^ tok_i.sum) + keys_i[key_idx];
    a_new   = encrypt ? (tok_i.a + mix) : (tok_i.a - mix);
    // step the sum after the first half-round only
    if (tok_i.phase) begin
      sum_new = tok_i.sum;
    end else if (encrypt) begin
      sum_new = tok_i.sum + tbc_pkg::TEA_DELTA;
    end else begin
      sum_new = tok_i.sum - tbc_pkg::TEA_DELTA;
    end
    tok_d       = tok_i;
    tok_d.phase = ~tok_i.phase;
    tok_d.a     = tok_i.b;
    tok_d.b     = a_new;
    tok_d.sum   = sum_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

// ===== rtl/tea_block_cipher_16_round.sv =====
// Top level of the pipelined TEA block cipher.
`timescale 1ns / 1ps

// A command is taken in every cycle in which start_i is high; busy_o stays low.
// Each block passes a chain of 2*ROUND_COUNT half-round cells, one cell per cycle,
// and its result shows on result_o with done_o high for one cycle, taken from the
// output register behind the last cell. Results come out in command order at one
// per cycle and must be taken when shown.
// Each block uses the key words as they stand while it moves through the
// chain, so write keys only while no block is in flight.
module tea_block_cipher_16_round #(
  parameter int unsigned ROUND_COUNT = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  tbc_pkg::cmd_t              cmd_i,
  output logic                       busy_o,
  output logic                       done_o,
  output tbc_pkg::result_t           result_o,
  input  logic                       cfg_we_i,
  input  logic [tbc_pkg::KEY_IDX_W-1:0] cfg_idx_i,
  input  logic [tbc_pkg::WORD_W-1:0] cfg_wdata_i
);

  localparam int unsigned NUM_CELLS = 2 * ROUND_COUNT;
  localparam logic [63:0] SUM_PROD = 64'(ROUND_COUNT) * 64'(tbc_pkg::TEA_DELTA);
  localparam logic [tbc_pkg::WORD_W-1:0] SUM_DECRYPT = SUM_PROD[tbc_pkg::WORD_W-1:0];

  tbc_pkg::keys_t   keys_q;
  tbc_pkg::token_t  tok [NUM_CELLS+1];
  tbc_pkg::token_t  tok_last;
  logic             done_q;
  tbc_pkg::result_t result_d;
  tbc_pkg::result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
    end else if (cfg_we_i) begin
      case (tbc_pkg::key_idx_e'(cfg_idx_i))
        tbc_pkg::KEY_WORD_0: keys_q[0] <= cfg_wdata_i;
        tbc_pkg::KEY_WORD_1: keys_q[1] <= cfg_wdata_i;
        tbc_pkg::KEY_WORD_2: keys_q[2] <= cfg_wdata_i;
        tbc_pkg::KEY_WORD_3: keys_q[3] <= cfg_wdata_i;
        default: keys_q <= keys_q;
      endcase
    end
  end

  // Decrypt updates the right half first, so it enters as the updated half.
  always_comb begin
    tok[0].valid = start_i;
    tok[0].op    = cmd_i.opcode;
    tok[0].phase = 1'b0;
    if (cmd_i.opcode == tbc_pkg::OP_ENCRYPT) begin
      tok[0].a   = cmd_i.block_left;
      tok[0].b   = cmd_i.block_right;
      tok[0].sum = '0;
    end else begin
      tok[0].a   = cmd_i.block_right;
      tok[0].b   = cmd_i.block_left;
      tok[0].sum = SUM_DECRYPT;
    end
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    tbc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .keys_i (keys_q),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  assign tok_last = tok[NUM_CELLS];

  // Halves swap in every cell, so after an even count they hold their entry roles.
  always_comb begin
    if (tok_last.op == tbc_pkg::OP_ENCRYPT) begin
      result_d.out_left  = tok_last.a;
      result_d.out_right = tok_last.b;
    end else begin
      result_d.out_left  = tok_last.b;
      result_d.out_right = tok_last.a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tok_last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign busy_o   = 1'b0;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== rtl/tbc_checker.sv =====
// Port-level checker for the TEA block cipher, bound to the top level.
`timescale 1ns / 1ps

module tbc_checker #(
  parameter int unsigned ROUND_COUNT = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  localparam int unsigned LATENCY = 2 * ROUND_COUNT + 1;

  // every accepted transaction yields a result after the fixed latency
  a_result_follows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o
  ) else $error("accepted transaction produced no result");

  // no result without a transaction accepted the fixed latency earlier
  a_no_spurious: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start_i, LATENCY) && !$past(busy_o, LATENCY))
  ) else $error("result without a matching transaction");

  // the pipeline takes a transaction in every cycle
  a_never_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o
  ) else $error("command refused");

endmodule

bind tea_block_cipher_16_round tbc_checker #(
  .ROUND_COUNT (ROUND_COUNT)
) u_tbc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
